FILE: hdl/sparse_fragment_array_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the sparse fragment table RTL.
// Each macro expects signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef SPARSE_FRAGMENT_ARRAY_TABLE_MACROS_SVH
`define SPARSE_FRAGMENT_ARRAY_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SFAT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define SFAT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define SFAT_IMPLIES_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/sfat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfat_pkg
// Sizes, operation codes and status codes of the sparse fragment table.
// ----------------------------------------------------------------------------
package sfat_pkg;

  localparam int NUM_FRAGS = 32;
  localparam int FRAG_LEN  = 32;
  localparam int CAPACITY  = NUM_FRAGS * FRAG_LEN;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int FRAG_W = $clog2(NUM_FRAGS);
  localparam int CELL_W = $clog2(FRAG_LEN);
  localparam int FILL_W = $clog2(FRAG_LEN + 1);
  localparam int ACT_W  = $clog2(NUM_FRAGS + 1);

  // Field widths of the item and result ports.
  localparam int KIND_W    = 3;
  localparam int INDEX_W   = 17;
  localparam int KEY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET      = 3'd0,
    KIND_GET      = 3'd1,
    KIND_DELETE   = 3'd2,
    KIND_CONTAINS = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_SET = 2'd2;

  // Number of cells covered by the allocated fragments, as reported.
  function automatic logic [CNT_W-1:0] alloc_cells(input logic [ACT_W-1:0] active);
    return CNT_W'(int'(active) * FRAG_LEN);
  endfunction

endpackage

FILE: hdl/sfat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfat_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module sfat_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sparse_fragment_array_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_fragment_array_table
// Sparse array of fragments with per-cell valid bits, fill counts per
// fragment and table-wide counts of used cells and allocated fragments.
// ----------------------------------------------------------------------------
// Usage: present kind, index and key with start high; the item is taken at a
// rising edge where start is high and busy is low. Exactly one result comes
// back for each item, on the result ports for a single cycle with done high.
// The receiver cannot stall, so results are never held back.
// Set, get, delete, clear and the unused kinds: the cell and its fragment's
// valid row are read from the RAMs at the accepting edge, and in the execute
// state they are written back and the result is registered. done is high in
// the cycle after that, and a new item can be taken in that same cycle.
// A contains search walks every cell through the RAM read port, one cell per
// cycle, and stops at the first hit or after the last cell.
// Clear empties the table by zeroing the fill counts: a fragment whose fill
// count is zero reads as having no valid cells, so the RAMs are never swept.
// Reset empties the table at once and needs no clearing pass; stored keys
// stay undefined until written.
// ----------------------------------------------------------------------------
`include "sparse_fragment_array_table_macros.svh"

module sparse_fragment_array_table
  import sfat_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [KIND_W-1:0]           kind,
  input  logic signed [INDEX_W-1:0]   index,
  input  logic signed [KEY_W-1:0]     key,
  output logic                        done,
  output logic [STATUS_W-1:0]         status,
  output logic signed [KEY_W-1:0]     read_value,
  output logic                        found,
  output logic [CNT_W-1:0]            used_cells,
  output logic [CNT_W-1:0]            allocated_cells,
  output logic                        fragment_spawned,
  output logic                        fragment_released
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t state;

  // Captured item.
  logic [KIND_W-1:0] kind_r;
  logic [IDX_W-1:0]  idx_r;
  logic [KEY_W-1:0]  key_r;
  logic              idx_ok_r;

  // Table counts and per-fragment fill counts.
  logic [CNT_W-1:0]  used_count;
  logic [ACT_W-1:0]  active_fragments;
  logic [FILL_W-1:0] fragment_fill [NUM_FRAGS];

  // Search walk: issue pointer and the check stage behind the RAM read.
  logic [IDX_W:0]    ptr;
  logic              chk_vld;
  logic              chk_alloc;
  logic              chk_last;
  logic [CELL_W-1:0] chk_cell;

  logic              accept;
  logic              idx_ok;
  logic [IDX_W-1:0]  rd_addr;
  logic [FRAG_W-1:0] fill_addr;
  logic [FILL_W-1:0] fill_cur;
  logic [FRAG_W-1:0] frag_r;
  logic [CELL_W-1:0] cell_r;

  logic [KEY_W-1:0]    store_rdata;
  logic [FRAG_LEN-1:0] row_rdata;
  logic [FRAG_LEN-1:0] row_eff;
  logic [FRAG_LEN-1:0] cell_bit;
  logic                was_set;
  logic                hit;

  logic                store_we;
  logic                row_we;
  logic [FRAG_LEN-1:0] row_wdata;
  logic                fill_we;
  logic                fill_clr;
  logic [FILL_W-1:0]   fill_next;

  logic [STATUS_W-1:0] status_next;
  logic [KEY_W-1:0]    rv_next;
  logic                found_next;
  logic                spawned_next;
  logic                released_next;
  logic [CNT_W-1:0]    used_next;
  logic [ACT_W-1:0]    active_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign idx_ok = !index[INDEX_W-1] &&
                  (index[INDEX_W-2:0] < (INDEX_W-1)'(CAPACITY));

  assign frag_r = FRAG_W'(idx_r / FRAG_LEN);
  assign cell_r = CELL_W'(idx_r % FRAG_LEN);

  // The RAMs are read straight from the item port while idle, so the data
  // are ready in the execute cycle; the walk reads at its own pointer.
  assign rd_addr   = (state == S_SCAN) ? ptr[IDX_W-1:0] : index[IDX_W-1:0];
  assign fill_addr = (state == S_SCAN) ? FRAG_W'(ptr[IDX_W-1:0] / FRAG_LEN) : frag_r;
  assign fill_cur  = fragment_fill[fill_addr];

  // A fragment with no used cells may hold a stale row from before a clear.
  assign row_eff  = (fill_cur == '0) ? '0 : row_rdata;
  assign cell_bit = FRAG_LEN'(1) << cell_r;
  assign was_set  = row_eff[cell_r];

  assign hit = chk_vld && chk_alloc && row_rdata[chk_cell] && (store_rdata == key_r);

  sfat_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (idx_r),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (store_rdata)
  );

  sfat_ram #(
    .DEPTH (NUM_FRAGS),
    .WIDTH (FRAG_LEN)
  ) u_valid (
    .clk   (clk),
    .we    (row_we),
    .waddr (frag_r),
    .wdata (row_wdata),
    .raddr (FRAG_W'(rd_addr / FRAG_LEN)),
    .rdata (row_rdata)
  );

  always_comb begin
    status_next   = ST_OK;
    rv_next       = '0;
    found_next    = 1'b0;
    spawned_next  = 1'b0;
    released_next = 1'b0;
    used_next     = used_count;
    active_next   = active_fragments;
    store_we      = 1'b0;
    row_we        = 1'b0;
    row_wdata     = row_eff;
    fill_we       = 1'b0;
    fill_clr      = 1'b0;
    fill_next     = fill_cur;
    if ((kind_r <= KIND_DELETE) && !idx_ok_r) begin
      status_next = ST_RANGE;
    end else begin
      case (kind_r)
        KIND_SET: begin
          store_we  = 1'b1;
          row_we    = 1'b1;
          row_wdata = row_eff | cell_bit;
          if (fill_cur == '0) begin
            spawned_next = 1'b1;
            active_next  = active_fragments + 1'b1;
          end
          if (!was_set) begin
            used_next = used_count + 1'b1;
            fill_we   = 1'b1;
            fill_next = fill_cur + 1'b1;
          end
        end
        KIND_GET: begin
          if (was_set) begin
            rv_next    = store_rdata;
            found_next = 1'b1;
          end else begin
            status_next = ST_NOT_SET;
          end
        end
        KIND_DELETE: begin
          if (!was_set) begin
            status_next = ST_NOT_SET;
          end else begin
            row_we    = 1'b1;
            row_wdata = row_eff & ~cell_bit;
            used_next = used_count - 1'b1;
            fill_we   = 1'b1;
            fill_next = fill_cur - 1'b1;
            if (fill_cur == FILL_W'(1)) begin
              released_next = 1'b1;
              active_next   = active_fragments - 1'b1;
            end
          end
        end
        KIND_CLEAR: begin
          fill_clr    = 1'b1;
          used_next   = '0;
          active_next = '0;
        end
        default: begin
        end
      endcase
    end
    if (state != S_EXEC) begin
      store_we = 1'b0;
      row_we   = 1'b0;
      fill_we  = 1'b0;
      fill_clr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      used_count       <= '0;
      active_fragments <= '0;
      chk_vld          <= 1'b0;
      for (int i = 0; i < NUM_FRAGS; i++) begin
        fragment_fill[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r   <= kind;
            idx_r    <= index[IDX_W-1:0];
            key_r    <= key;
            idx_ok_r <= idx_ok;
            ptr      <= '0;
            chk_vld  <= 1'b0;
            state    <= (kind == KIND_CONTAINS) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          done              <= 1'b1;
          status            <= status_next;
          read_value        <= rv_next;
          found             <= found_next;
          used_cells        <= used_next;
          allocated_cells   <= alloc_cells(active_next);
          fragment_spawned  <= spawned_next;
          fragment_released <= released_next;
          used_count        <= used_next;
          active_fragments  <= active_next;
          if (fill_clr) begin
            for (int i = 0; i < NUM_FRAGS; i++) begin
              fragment_fill[i] <= '0;
            end
          end else if (fill_we) begin
            fragment_fill[frag_r] <= fill_next;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (ptr < (IDX_W+1)'(CAPACITY)) begin
            ptr       <= ptr + 1'b1;
            chk_vld   <= 1'b1;
            chk_alloc <= (fill_cur != '0);
            chk_cell  <= CELL_W'(ptr[IDX_W-1:0] % FRAG_LEN);
            chk_last  <= (ptr == (IDX_W+1)'(CAPACITY - 1));
          end else begin
            chk_vld <= 1'b0;
          end
          if (chk_vld && (hit || chk_last)) begin
            done              <= 1'b1;
            status            <= ST_OK;
            read_value        <= '0;
            found             <= hit;
            used_cells        <= used_count;
            allocated_cells   <= alloc_cells(active_fragments);
            fragment_spawned  <= 1'b0;
            fragment_released <= 1'b0;
            chk_vld           <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SFAT_IMPLIES(a_done_when_idle, done, !busy, "result shown while an item is still at work")
  `SFAT_IMPLIES_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `SFAT_HOLDS(a_empty_consistent, (used_count == '0) == (active_fragments == '0), "cell and fragment counts disagree")
  `SFAT_IMPLIES(a_flags_exclusive, done, !(fragment_spawned && fragment_released), "spawn and release in one result")
  `SFAT_HOLDS(a_used_bound, used_count <= CNT_W'(CAPACITY), "used cell count beyond capacity")

endmodule

FILE: tb/sparse_fragment_array_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_fragment_array_table_checker
// Watches the item and result channels of the sparse fragment table, keeps a
// shadow copy of the table, predicts the reply to every accepted item and
// compares each reply with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sparse_fragment_array_table_checker
  import sfat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [INDEX_W-1:0] index,
  input  logic signed [KEY_W-1:0]   key,
  input  logic                      done,
  input  logic [STATUS_W-1:0]       status,
  input  logic signed [KEY_W-1:0]   read_value,
  input  logic                      found,
  input  logic [CNT_W-1:0]          used_cells,
  input  logic [CNT_W-1:0]          allocated_cells,
  input  logic                      fragment_spawned,
  input  logic                      fragment_released,
  output int                        failures,
  output int                        outstanding
);

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    read_value;
    logic                found;
    logic [CNT_W-1:0]    used_cells;
    logic [CNT_W-1:0]    allocated_cells;
    logic                spawned;
    logic                released;
  } table_reply_t;

  logic [KEY_W-1:0] shadow_key   [CAPACITY];
  bit               shadow_valid [CAPACITY];
  int unsigned      shadow_fill  [NUM_FRAGS];
  int unsigned      shadow_used;
  int unsigned      shadow_active;

  table_reply_t expected_replies [$];
  table_reply_t want;
  int           mismatch_count;

  assign failures = mismatch_count;

  function automatic void empty_shadow();
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    foreach (shadow_fill[f]) shadow_fill[f] = 0;
    shadow_used   = 0;
    shadow_active = 0;
  endfunction

  // Applies one operation to the shadow table and returns the reply it gives.
  function automatic table_reply_t apply_table_op(input logic [KIND_W-1:0] op,
                                                  input logic signed [INDEX_W-1:0] idx,
                                                  input logic [KEY_W-1:0] value);
    table_reply_t r;
    bit           in_range;
    int unsigned  pos;
    int unsigned  frag;
    r = '{ST_OK, '0, 1'b0, '0, '0, 1'b0, 1'b0};
    in_range = (idx >= 0) && (idx < CAPACITY);
    pos  = in_range ? int'(idx) : 0;
    frag = pos / FRAG_LEN;
    if (op <= KIND_DELETE && !in_range) begin
      r.status = ST_RANGE;
    end else begin
      case (op)
        KIND_SET: begin
          if (shadow_fill[frag] == 0) begin
            shadow_active++;
            r.spawned = 1'b1;
          end
          if (!shadow_valid[pos]) begin
            shadow_valid[pos] = 1'b1;
            shadow_used++;
            shadow_fill[frag]++;
          end
          shadow_key[pos] = value;
        end
        KIND_GET: begin
          if (shadow_valid[pos]) begin
            r.read_value = shadow_key[pos];
            r.found      = 1'b1;
          end else begin
            r.status = ST_NOT_SET;
          end
        end
        KIND_DELETE: begin
          if (!shadow_valid[pos]) begin
            r.status = ST_NOT_SET;
          end else begin
            shadow_valid[pos] = 1'b0;
            shadow_used--;
            shadow_fill[frag]--;
            if (shadow_fill[frag] == 0) begin
              shadow_active--;
              r.released = 1'b1;
            end
          end
        end
        KIND_CONTAINS: begin
          // Only fragments that hold at least one set cell are searched.
          for (int f = 0; f < NUM_FRAGS; f++) begin
            if (shadow_fill[f] != 0) begin
              for (int c = 0; c < FRAG_LEN; c++) begin
                if (shadow_valid[f * FRAG_LEN + c] && shadow_key[f * FRAG_LEN + c] == value)
                  r.found = 1'b1;
              end
            end
          end
        end
        KIND_CLEAR: empty_shadow();
        default: ;
      endcase
    end
    r.used_cells      = CNT_W'(shadow_used);
    r.allocated_cells = CNT_W'(shadow_active * FRAG_LEN);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [KEY_W-1:0] expected,
                               input logic [KEY_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, actual %0h", field, expected, actual);
      mismatch_count++;
    end
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      empty_shadow();
      expected_replies.delete();
    end else begin
      // The reply seen at this edge belongs to an earlier item, so it is
      // matched before the item taken at this edge is predicted.
      if (done) begin
        if (expected_replies.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("status", want.status, status);
          compare_field("read_value", want.read_value, read_value);
          compare_field("found", want.found, found);
          compare_field("used_cells", want.used_cells, used_cells);
          compare_field("allocated_cells", want.allocated_cells, allocated_cells);
          compare_field("fragment_spawned", want.spawned, fragment_spawned);
          compare_field("fragment_released", want.released, fragment_released);
        end
      end
      if (start && !busy)
        expected_replies.push_back(apply_table_op(kind, index, key));
    end
    outstanding <= expected_replies.size();
  end

endmodule

FILE: tb/sparse_fragment_array_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_fragment_array_table_test
// Drives the sparse fragment table with a directed opening and then random
// episodes of set, get and delete on a few hot fragments, mixed with searches,
// clears, out-of-range indices and spare kinds, in bursts with random gaps.
// ----------------------------------------------------------------------------
module sparse_fragment_array_table_test;
  import sfat_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 20;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [KIND_W-1:0]         kind;
  logic signed [INDEX_W-1:0] index;
  logic signed [KEY_W-1:0]   key;
  logic                      done;
  logic [STATUS_W-1:0]       status;
  logic signed [KEY_W-1:0]   read_value;
  logic                      found;
  logic [CNT_W-1:0]          used_cells;
  logic [CNT_W-1:0]          allocated_cells;
  logic                      fragment_spawned;
  logic                      fragment_released;
  int                        failures;
  int                        outstanding;

  int               burst_left;
  logic [KEY_W-1:0] key_pool [8];

  sparse_fragment_array_table DUT (.*);

  sparse_fragment_array_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Presents one item, holds it until taken, then possibly idles for a while.
  task automatic issue_item(input logic [KIND_W-1:0] k, input int i,
                            input logic [KEY_W-1:0] v);
    int gap;
    start <= 1'b1;
    kind  <= k;
    index <= INDEX_W'(i);
    key   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    return ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
  endfunction

  // Cycles with neither an item nor a result taken; a long search is the
  // slowest legitimate case.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && !busy) || done)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) break;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int issued;
    int hot_frag;
    int window;
    int set_bias;
    int episode_left;
    int pick;
    int slot;
    rst   = 1'b1;
    start = 1'b0;
    kind  = '0;
    index = '0;
    key   = '0;
    burst_left = 0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int p = 4; p < 8; p++) key_pool[p] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty table, extremes of key and index, overwrite, search hit and miss.
    issue_item(KIND_GET, 0, 32'h0);
    issue_item(KIND_DELETE, 0, 32'h0);
    issue_item(KIND_SET, 0, 32'h7FFF_FFFF);
    issue_item(KIND_SET, 1, 32'h8000_0000);
    issue_item(KIND_SET, 0, 32'hFFFF_FFFF);
    issue_item(KIND_GET, 0, 32'h0);
    issue_item(KIND_GET, 1, 32'h0);
    issue_item(KIND_SET, CAPACITY - 1, 32'h0);
    issue_item(KIND_GET, CAPACITY - 1, 32'h0);
    issue_item(KIND_CONTAINS, 0, 32'hFFFF_FFFF);
    issue_item(KIND_CONTAINS, 0, 32'h0001_2345);
    // Out-of-range indices at both ends.
    issue_item(KIND_SET, -1, 32'h1);
    issue_item(KIND_SET, CAPACITY, 32'h1);
    issue_item(KIND_GET, -65536, 32'h0);
    issue_item(KIND_DELETE, 65535, 32'h0);
    issue_item(KIND_SET, 65535, 32'hA5A5_A5A5);
    // Emptying a fragment releases it; a second delete finds nothing.
    issue_item(KIND_DELETE, 1, 32'h0);
    issue_item(KIND_DELETE, 0, 32'h0);
    issue_item(KIND_DELETE, 0, 32'h0);
    issue_item(KIND_SPARE_LO, 5, 32'h5);
    issue_item(KIND_SPARE_LO + 3'd1, 6, 32'h6);
    issue_item(KIND_SPARE_HI, -7, 32'hFFFF_FFF9);
    issue_item(KIND_CLEAR, 3, 32'h3);
    issue_item(KIND_GET, CAPACITY - 1, 32'h0);
    issue_item(KIND_CONTAINS, 0, 32'h0);

    issued = 0;
    episode_left = 0;
    hot_frag = 0;
    window = 1;
    set_bias = 50;
    while (issued < RANDOM_ITEMS) begin
      // Each episode works a narrow window of one fragment so that fragments
      // fill up, drain and get released again.
      if (episode_left == 0) begin
        episode_left = $urandom_range(10, 40);
        hot_frag     = $urandom_range(0, NUM_FRAGS - 1);
        window       = $urandom_range(1, FRAG_LEN);
        set_bias     = $urandom_range(30, 80);
      end
      episode_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        issue_item(KIND_CLEAR, $urandom_range(0, 131071), $urandom);
      end else if (pick < 6) begin
        issue_item(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                   $urandom_range(0, 131071), $urandom);
      end else if (pick < 14) begin
        issue_item(KIND_CONTAINS, $urandom_range(0, 131071), pick_key());
      end else if (pick < 20) begin
        slot = ($urandom_range(0, 1) == 0) ? -int'($urandom_range(1, 65536))
                                           : int'($urandom_range(CAPACITY, 65535));
        issue_item(KIND_W'($urandom_range(KIND_SET, KIND_DELETE)), slot, pick_key());
      end else begin
        slot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CAPACITY - 1)
                                           : hot_frag * FRAG_LEN + $urandom_range(0, window - 1);
        pick = $urandom_range(0, 99);
        if (pick < set_bias)
          issue_item(KIND_SET, slot, pick_key());
        else if (pick[0])
          issue_item(KIND_GET, slot, $urandom);
        else
          issue_item(KIND_DELETE, slot, $urandom);
      end
      issued++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
